// File: rtl/core/lrukv_pkg.sv
package lrukv_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 16;

   localparam int DATA_WIDTH     = 32;
   localparam int CAPACITY_WIDTH = 5;

   localparam logic [CAPACITY_WIDTH-1:0] CAPACITY_RESET = 5'd16;

   // operation codes carried on func
   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   // read_value of a get that misses
   localparam logic [DATA_WIDTH-1:0] MISS_VALUE = 32'hFFFF_FFFF;
   // read_value of every put
   localparam logic [DATA_WIDTH-1:0] PUT_VALUE  = 32'h0000_0000;

endpackage

// File: rtl/core/lrukv_entry_ram.sv
module lrukv_entry_ram
   import lrukv_pkg::*;
#(
   parameter int DEPTH  = DEFAULT_MAX_ENTRIES,
   parameter int ADDR_W = 4,
   parameter int WIDTH  = 68
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Each item is a get (func 0) or a put (func 1). A get that hits returns the
// stored value with found=1 and makes the entry the most recent; a miss returns
// found=0 and read_value all ones. A put returns found (key already present)
// and read_value 0; it overwrites on a hit, otherwise inserts the pair as the
// most recent entry, evicting the least recent one once capacity entries are
// held. Writing the capacity register (0 acts as 1, above MAX_ENTRIES acts as
// MAX_ENTRIES) empties the table; write it only while the cache is idle.
// Timing: one entry RAM (key, value, rank) is swept one slot per cycle by a
// single compare unit. Each item runs a lookup sweep, a decision state, a
// rank/write-back sweep (skipped by a get miss), result load and idle before
// the next item is accepted. req_stall is high while an item is in work.
// The result sits in an output register, so the next item is taken while it
// waits on rsp_stall. No clearing pass: per-slot valid bits reset at once.
module lru_key_value_cache
   import lrukv_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_func,
   input  logic signed [DATA_WIDTH-1:0] req_key,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic signed [DATA_WIDTH-1:0] rsp_read_value,
   // capacity register
   input  logic                      csr_wr_en,
   input  logic [CAPACITY_WIDTH-1:0] csr_wr_data
);

   localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int RANK_W  = IDX_W;
   localparam int ENTRY_W = 2 * DATA_WIDTH + RANK_W;
   localparam int CMP_W   = (CNT_W > CAPACITY_WIDTH) ? CNT_W : CAPACITY_WIDTH;

   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_ENTRIES);
   localparam logic [CMP_W-1:0] MAX_CAP  = CMP_W'(MAX_ENTRIES);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   // item being worked on
   logic                      func_ff, func_in;
   logic [DATA_WIDTH-1:0]     key_ff, key_in;
   logic [DATA_WIDTH-1:0]     value_ff, value_in;

   // table state
   logic [CAPACITY_WIDTH-1:0] capacity_ff, capacity_in;
   logic [MAX_ENTRIES-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   // lookup sweep results
   logic                      hit_ff, hit_in;
   logic [IDX_W-1:0]          hit_slot_ff, hit_slot_in;
   logic [RANK_W-1:0]         hit_rank_ff, hit_rank_in;
   logic [DATA_WIDTH-1:0]     hit_value_ff, hit_value_in;
   logic                      free_found_ff, free_found_in;
   logic [IDX_W-1:0]          free_slot_ff, free_slot_in;
   logic                      lru_found_ff, lru_found_in;
   logic [IDX_W-1:0]          lru_slot_ff, lru_slot_in;
   logic [RANK_W-1:0]         lru_rank_ff, lru_rank_in;

   // slot that becomes most recent during the write-back sweep
   logic [IDX_W-1:0]          tgt_slot_ff, tgt_slot_in;

   // pending result and output register
   logic                      pend_found_ff, pend_found_in;
   logic [DATA_WIDTH-1:0]     pend_value_ff, pend_value_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [DATA_WIDTH-1:0]     rsp_value_ff, rsp_value_in;

   // entry RAM port
   logic                      ram_wr_en;
   logic [IDX_W-1:0]          ram_wr_addr;
   logic [ENTRY_W-1:0]        ram_wr_data;
   logic [IDX_W-1:0]          ram_rd_addr;
   logic [ENTRY_W-1:0]        ram_rd_data;

   // slot whose read data is on ram_rd_data this cycle
   logic [CNT_W-1:0]          proc_cnt;
   logic [IDX_W-1:0]          proc_idx;
   logic [DATA_WIDTH-1:0]     e_key;
   logic [DATA_WIDTH-1:0]     e_value;
   logic [RANK_W-1:0]         e_rank;
   logic                      e_valid;

   logic [CMP_W-1:0]          cap_ext;
   logic [CMP_W-1:0]          eff_cap;
   logic                      table_full;
   logic                      req_take;
   logic                      rsp_free;
   logic                      bump;

   lrukv_entry_ram #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (IDX_W),
      .WIDTH  (ENTRY_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_take = req_valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // clamp capacity into 1..MAX_ENTRIES
   assign cap_ext    = CMP_W'(capacity_ff);
   assign eff_cap    = (cap_ext == '0) ? CMP_W'(1) :
                       ((cap_ext > MAX_CAP) ? MAX_CAP : cap_ext);
   assign table_full = CMP_W'(count_ff) >= eff_cap;

   // sweep: address cnt is read, slot cnt-1 is processed
   assign ram_rd_addr = (cnt_ff < LAST_CNT) ? cnt_ff[IDX_W-1:0] : '0;
   assign proc_cnt    = cnt_ff - CNT_W'(1);
   assign proc_idx    = proc_cnt[IDX_W-1:0];
   assign e_key       = ram_rd_data[ENTRY_W-1 -: DATA_WIDTH];
   assign e_value     = ram_rd_data[RANK_W +: DATA_WIDTH];
   assign e_rank      = ram_rd_data[RANK_W-1:0];
   assign e_valid     = valid_ff[proc_idx];

   // promote: younger entries age; insert: every valid entry ages
   assign bump = e_valid && (!hit_ff || (e_rank < hit_rank_ff));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      capacity_in   = capacity_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      hit_rank_in   = hit_rank_ff;
      hit_value_in  = hit_value_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      lru_found_in  = lru_found_ff;
      lru_slot_in   = lru_slot_ff;
      lru_rank_in   = lru_rank_ff;
      tgt_slot_in   = tgt_slot_ff;
      pend_found_in = pend_found_ff;
      pend_value_in = pend_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = proc_idx;
      ram_wr_data   = ram_rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in       = req_func;
               key_in        = req_key;
               value_in      = req_value;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               lru_found_in  = 1'b0;
               cnt_in        = '0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0) begin
               // first valid match wins
               if (e_valid && (e_key == key_ff) && !hit_ff) begin
                  hit_in       = 1'b1;
                  hit_slot_in  = proc_idx;
                  hit_rank_in  = e_rank;
                  hit_value_in = e_value;
               end
               // lowest free slot
               if (!e_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = proc_idx;
               end
               // oldest valid entry
               if (e_valid && (!lru_found_ff || (e_rank > lru_rank_ff))) begin
                  lru_found_in = 1'b1;
                  lru_slot_in  = proc_idx;
                  lru_rank_in  = e_rank;
               end
            end
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            cnt_in        = '0;
            pend_found_in = hit_ff;
            state_in      = ST_UPDATE;
            if (func_ff == FUNC_GET) begin
               pend_value_in = hit_ff ? hit_value_ff : MISS_VALUE;
               tgt_slot_in   = hit_slot_ff;
               if (!hit_ff) begin
                  state_in = ST_RESP;
               end
            end else begin
               pend_value_in = PUT_VALUE;
               if (hit_ff) begin
                  tgt_slot_in = hit_slot_ff;
               end else if (table_full && lru_found_ff) begin
                  // evicted slot is reused, count unchanged
                  tgt_slot_in = lru_slot_ff;
               end else begin
                  tgt_slot_in             = free_slot_ff;
                  valid_in[free_slot_ff]  = 1'b1;
                  count_in                = count_ff + CNT_W'(1);
               end
            end
         end

         ST_UPDATE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0) begin
               ram_wr_en = 1'b1;
               if (proc_idx == tgt_slot_ff) begin
                  ram_wr_data = {key_ff,
                                 (func_ff == FUNC_PUT) ? value_ff : e_value,
                                 RANK_W'(0)};
               end else begin
                  ram_wr_data = {e_key, e_value, e_rank + RANK_W'(bump)};
               end
            end
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = pend_found_ff;
               rsp_value_in = pend_value_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capacity write empties the table
      if (csr_wr_en) begin
         capacity_in = csr_wr_data;
         valid_in    = '0;
         count_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAPACITY_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      func_ff       <= func_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      hit_rank_ff   <= hit_rank_in;
      hit_value_ff  <= hit_value_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      lru_found_ff  <= lru_found_in;
      lru_slot_ff   <= lru_slot_in;
      lru_rank_ff   <= lru_rank_in;
      tgt_slot_ff   <= tgt_slot_in;
      pend_found_ff <= pend_found_in;
      pend_value_ff <= pend_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

// File: rtl/core/lrukv_checker.sv
module lrukv_checker
   import lrukv_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_found,
   input logic [DATA_WIDTH-1:0]     rsp_read_value
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
                                 && $stable(rsp_read_value))
      else $error("stalled item changed");

   // a miss reads all ones (get) or zero (put)
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_read_value == MISS_VALUE)
                                  || (rsp_read_value == PUT_VALUE))
      else $error("miss with bad read_value");

   // one item at a time: busy right after acceptance
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted back to back");

   // lookup sweep takes time, no result right after acceptance
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result without lookup");

endmodule

bind lru_key_value_cache lrukv_checker u_lrukv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_found      (rsp_found),
   .rsp_read_value (rsp_read_value)
);
